>>> src/tcw_pkg.sv
// Package for the text console writer: sizes, codes and shared types.
// Used by the channel interfaces, the timer, the top level and the port checker.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS   = 40;
    localparam int ROWS      = 25;
    localparam int LOG_LINES = 4;

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 5;
    localparam int ELAPSED_W = 12;
    localparam int HOLD_W    = 16;

    localparam int SP_W      = $clog2(ROWS);
    localparam int LP_W      = (LOG_LINES > 1) ? $clog2(LOG_LINES) : 1;
    localparam int SCR_DEPTH = ROWS * COLUMNS;
    localparam int SCR_AW    = $clog2(SCR_DEPTH);
    localparam int LOG_DEPTH = LOG_LINES * COLUMNS;
    localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    localparam logic [HOLD_W-1:0] HOLD_RESET   = HOLD_W'(4000);
    localparam logic [CHAR_W-1:0] CH_CR        = CHAR_W'(13);
    localparam logic [CHAR_W-1:0] CH_LF        = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] CH_PRINT_MIN = CHAR_W'(32);

    typedef enum logic [1:0] {
        ACT_PRINT       = 2'd0,
        ACT_TICK        = 2'd1,
        ACT_READ_SCREEN = 2'd2,
        ACT_READ_LOG    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_RDWAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 tick;
        logic                 clear;
        logic [ELAPSED_W-1:0] elapsed;
    } timer_cmd_t;

endpackage

`default_nettype wire

>>> src/tcw_if.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on tcw_pkg for field widths and the action code type.
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    action_t              action;
    logic [CHAR_W-1:0]    char_code;
    logic [ELAPSED_W-1:0] elapsed;
    logic [ROW_W-1:0]     read_row;
    logic [COL_W-1:0]     read_col;

    modport source (output valid, action, char_code, elapsed, read_row, read_col,
                    input ready);
    modport sink   (input valid, action, char_code, elapsed, read_row, read_col,
                    output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;

    modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HOLD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/tcw_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies; width and depth set per instance.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/tcw_timer.sv
// Message hold timer and the hold-time configuration register.
// Depends on tcw_pkg and the tcw_cfg_if interface.
`default_nettype none

module tcw_timer import tcw_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tcw_cfg_if.sink         cfg,
    input  wire timer_cmd_t cmd,
    output logic            hit
);

    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [HOLD_W-1:0] timer_reg, timer_next;
    logic [HOLD_W:0]   sum;
    logic [HOLD_W-1:0] sat_sum;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        sum     = {1'b0, timer_reg} + (HOLD_W+1)'(cmd.elapsed);
        // saturate before the compare
        sat_sum = sum[HOLD_W] ? {HOLD_W{1'b1}} : sum[HOLD_W-1:0];
        hit     = cmd.tick && (sat_sum >= hold_reg);

        hold_next  = cfg.valid ? cfg.data : hold_reg;
        timer_next = timer_reg;
        if (cmd.clear || hit)
        begin
            timer_next = '0;
        end
        else if (cmd.tick)
        begin
            timer_next = sat_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= HOLD_RESET;
            timer_reg <= '0;
        end
        else
        begin
            hold_reg  <= hold_next;
            timer_reg <= timer_next;
        end
    end

endmodule

`default_nettype wire

>>> src/text_console_writer_unit.sv
// Text console writer top level: sequencer, screen and log RAMs, cursor state.
// Depends on tcw_pkg, tcw_if, tcw_ram and tcw_timer.
//
//   channel | dir | handshake        | word
//   --------+-----+------------------+-------------------------------------------
//   req     | in  | valid/ready      | action, char_code, elapsed, read_row/col
//   rsp     | out | valid/ready      | cell_value, cursor_col, cursor_row
//   cfg     | in  | valid/ready      | data = message_hold_time (always ready)
//
// States per word: tick and control bytes pass IDLE, EMIT; reads pass IDLE, RDWAIT
// (registered RAM read), EMIT; a printable byte passes IDLE, FILL, EMIT, and FILL first
// sweeps the row to zero when the target screen row or the last log line is not valid.
// Scrolls move a row pointer and drop a per-row valid bit, so they cost no sweep.
// Reset is asynchronous; no clearing pass runs, rows read as zero until written.
// A finished word waits in the output register; the next word is taken meanwhile.
`default_nettype none

module text_console_writer_unit import tcw_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp,
    tcw_cfg_if.sink   cfg
);

    state_t state_reg, state_next;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SP_W-1:0]   scr_top_reg, scr_top_next;
    logic [LP_W-1:0]   log_top_reg, log_top_next;
    logic [ROWS-1:0]   scr_valid_reg, scr_valid_next;
    logic [LOG_LINES-1:0] log_valid_reg, log_valid_next;

    logic [COL_W-1:0]  fill_col_reg, fill_col_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [SP_W-1:0]   p_reg, p_next;
    logic [LP_W-1:0]   q_reg, q_next;
    logic              fill_s_reg, fill_s_next;
    logic              fill_l_reg, fill_l_next;
    logic              rd_hit_reg, rd_hit_next;
    logic              rd_log_reg, rd_log_next;
    logic [CHAR_W-1:0] cell_reg, cell_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_cell_reg, out_cell_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              scr_we, log_we;
    logic [SCR_AW-1:0] scr_addr;
    logic [LOG_AW-1:0] log_addr;
    logic [CHAR_W-1:0] scr_wdata, log_wdata, scr_rdata, log_rdata;

    timer_cmd_t        timer_cmd;
    logic              timer_hit;

    logic              do_next_line, do_log_scroll, fill_last;
    logic [SP_W-1:0]   cur_p, rd_p;
    logic [LP_W-1:0]   log_last, rd_q;
    logic [COL_W-1:0]  scr_col, log_col;
    logic [COL_W:0]    col_inc;
    logic              scr_in_range, log_in_range;

    function automatic logic [SP_W-1:0] scr_phys(input logic [SP_W-1:0] top,
                                                 input logic [ROW_W-1:0] r);
        logic [SP_W:0] s;
        s = {1'b0, top} + (SP_W+1)'(r);
        if (s >= (SP_W+1)'(ROWS))
        begin
            s = s - (SP_W+1)'(ROWS);
        end
        return s[SP_W-1:0];
    endfunction

    function automatic logic [LP_W-1:0] log_phys(input logic [LP_W-1:0] top,
                                                 input logic [LP_W-1:0] r);
        logic [LP_W:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= (LP_W+1)'(LOG_LINES))
        begin
            s = s - (LP_W+1)'(LOG_LINES);
        end
        return s[LP_W-1:0];
    endfunction

    function automatic logic [SCR_AW-1:0] scr_cell(input logic [SP_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return SCR_AW'(r) * SCR_AW'(COLUMNS) + SCR_AW'(c);
    endfunction

    function automatic logic [LOG_AW-1:0] log_cell(input logic [LP_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return LOG_AW'(r) * LOG_AW'(COLUMNS) + LOG_AW'(c);
    endfunction

    tcw_ram #(.WIDTH(CHAR_W), .DEPTH(SCR_DEPTH)) u_scr_ram (
        .clk   (clk),
        .we    (scr_we),
        .addr  (scr_addr),
        .wdata (scr_wdata),
        .rdata (scr_rdata)
    );

    tcw_ram #(.WIDTH(CHAR_W), .DEPTH(LOG_DEPTH)) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .addr  (log_addr),
        .wdata (log_wdata),
        .rdata (log_rdata)
    );

    tcw_timer u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (timer_cmd),
        .hit   (timer_hit)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_value = out_cell_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cursor_row = out_row_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        scr_top_next   = scr_top_reg;
        log_top_next   = log_top_reg;
        scr_valid_next = scr_valid_reg;
        log_valid_next = log_valid_reg;
        fill_col_next  = fill_col_reg;
        ch_next        = ch_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        fill_s_next    = fill_s_reg;
        fill_l_next    = fill_l_reg;
        rd_hit_next    = rd_hit_reg;
        rd_log_next    = rd_log_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_cell_next  = out_cell_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;

        req.ready      = 1'b0;
        scr_we         = 1'b0;
        log_we         = 1'b0;
        scr_addr       = '0;
        log_addr       = '0;
        scr_wdata      = '0;
        log_wdata      = '0;
        timer_cmd      = '0;
        do_next_line   = 1'b0;
        do_log_scroll  = 1'b0;

        cur_p    = scr_phys(scr_top_reg, row_reg);
        log_last = (log_top_reg == '0) ? LP_W'(LOG_LINES - 1) : log_top_reg - 1'b1;
        rd_p     = scr_phys(scr_top_reg, req.read_row);
        rd_q     = log_phys(log_top_reg, req.read_row[LP_W-1:0]);
        scr_in_range = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLUMNS);
        log_in_range = (32'(req.read_row) < LOG_LINES) && (32'(req.read_col) < COLUMNS);

        scr_col   = fill_s_reg ? fill_col_reg : col_reg;
        log_col   = fill_l_reg ? fill_col_reg : col_reg;
        fill_last = !(fill_s_reg || fill_l_reg) || (fill_col_reg == COL_W'(COLUMNS - 1));
        col_inc   = {1'b0, col_reg} + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cell_next = '0;
                    unique case (req.action)
                        ACT_PRINT:
                        begin
                            state_next = ST_EMIT;
                            if (req.char_code >= CH_PRINT_MIN)
                            begin
                                ch_next       = req.char_code;
                                p_next        = cur_p;
                                q_next        = log_last;
                                fill_s_next   = !scr_valid_reg[cur_p];
                                fill_l_next   = !log_valid_reg[log_last];
                                fill_col_next = '0;
                                state_next    = ST_FILL;
                            end
                            else if (req.char_code == CH_CR)
                            begin
                                col_next = '0;
                            end
                            else if (req.char_code == CH_LF)
                            begin
                                do_next_line = 1'b1;
                            end
                        end
                        ACT_TICK:
                        begin
                            timer_cmd.tick    = 1'b1;
                            timer_cmd.elapsed = req.elapsed;
                            do_log_scroll     = timer_hit;
                            state_next        = ST_EMIT;
                        end
                        ACT_READ_SCREEN:
                        begin
                            scr_addr    = scr_cell(rd_p, req.read_col);
                            rd_hit_next = scr_in_range && scr_valid_reg[rd_p];
                            rd_log_next = 1'b0;
                            state_next  = ST_RDWAIT;
                        end
                        ACT_READ_LOG:
                        begin
                            log_addr    = log_cell(rd_q, req.read_col);
                            rd_hit_next = log_in_range && log_valid_reg[rd_q];
                            rd_log_next = 1'b1;
                            state_next  = ST_RDWAIT;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                // sweep a fresh row to zero, dropping the byte in at the cursor; with no sweep, write just the byte
                scr_we    = fill_s_reg || (fill_col_reg == '0);
                scr_addr  = scr_cell(p_reg, scr_col);
                scr_wdata = (!fill_s_reg || fill_col_reg == col_reg) ? ch_reg : '0;
                log_we    = fill_l_reg || (fill_col_reg == '0);
                log_addr  = log_cell(q_reg, log_col);
                log_wdata = (!fill_l_reg || fill_col_reg == col_reg) ? ch_reg : '0;
                if (fill_last)
                begin
                    scr_valid_next[p_reg] = 1'b1;
                    log_valid_next[q_reg] = 1'b1;
                    if (col_inc == (COL_W+1)'(COLUMNS))
                    begin
                        do_next_line = 1'b1;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end

            ST_RDWAIT:
            begin
                if (rd_hit_reg)
                begin
                    cell_next = rd_log_reg ? log_rdata : scr_rdata;
                end
                else
                begin
                    cell_next = '0;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cell_reg;
                    out_col_next   = col_next;
                    out_row_next   = row_next;
                    state_next     = ST_IDLE;
                end
            end
        endcase

        if (do_next_line)
        begin
            col_next      = '0;
            do_log_scroll = 1'b1;
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                // old top row becomes the cleared bottom row
                scr_valid_next[scr_top_reg] = 1'b0;
                scr_top_next = (scr_top_reg == SP_W'(ROWS - 1)) ? '0 : scr_top_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        if (do_log_scroll)
        begin
            timer_cmd.clear             = 1'b1;
            log_valid_next[log_top_reg] = 1'b0;
            log_top_next = (log_top_reg == LP_W'(LOG_LINES - 1)) ? '0 : log_top_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            scr_top_reg   <= '0;
            log_top_reg   <= '0;
            scr_valid_reg <= '0;
            log_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            scr_top_reg   <= scr_top_next;
            log_top_reg   <= log_top_next;
            scr_valid_reg <= scr_valid_next;
            log_valid_reg <= log_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_col_reg <= fill_col_next;
        ch_reg       <= ch_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        fill_s_reg   <= fill_s_next;
        fill_l_reg   <= fill_l_next;
        rd_hit_reg   <= rd_hit_next;
        rd_log_reg   <= rd_log_next;
        cell_reg     <= cell_next;
        out_cell_reg <= out_cell_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
    end

endmodule

`default_nettype wire

>>> src/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg for screen sizes.
`default_nettype none

module tcw_checker import tcw_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [CHAR_W-1:0] cell_value,
    input wire logic [COL_W-1:0]  cursor_col,
    input wire logic [ROW_W-1:0]  cursor_row
);

    logic [1:0] pend_reg, pend_next;
    logic       req_acc, rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (req_acc && !rsp_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!req_acc && rsp_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_value)
            && $stable(cursor_col) && $stable(cursor_row))
        else $error("rsp word changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("rsp word without an accepted req word");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> pend_reg <= 2'd1)
        else $error("more than one req word in flight besides the output register");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(cursor_col) < COLUMNS) && (32'(cursor_row) < ROWS))
        else $error("cursor outside the screen");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cell_value (rsp.cell_value),
    .cursor_col (rsp.cursor_col),
    .cursor_row (rsp.cursor_row)
);

`default_nettype wire
